### rtl/dfs_visit_order_macros.svh
// assertion macros used by the dfs visit order block
`ifndef DFS_VISIT_ORDER_MACROS_SVH
`define DFS_VISIT_ORDER_MACROS_SVH

`ifndef SYNTHESIS
// checked property, masked while reset is active
`define DFS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dfs_visit_order: assertion failed");
// checked property, also evaluated during reset
`define DFS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("dfs_visit_order: assertion failed");
`else
`define DFS_ASSERT(lbl, prop)
`define DFS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### rtl/dfs_pkg.sv
`timescale 1ns / 1ps

package dfs_pkg;

  // node number width fixed by the field definitions
  localparam int NODE_W = 3;

  // default graph size
  localparam int NODE_COUNT_DEF = 5;

  // reset value of the trigger register
  localparam logic [NODE_W-1:0] TRIG_RESET = 3'd3;

  // configuration register indexes
  localparam logic CFG_ADJ  = 1'b0;
  localparam logic CFG_TRIG = 1'b1;

  // outcome of one neighbor test
  typedef struct packed {
    logic exhausted;  // all neighbors of the top node tried
    logic take;       // neighbor is an unvisited successor, descend
  } step_t;

endpackage

### rtl/dfs_step_unit.sv
`timescale 1ns / 1ps

module dfs_step_unit #(
  parameter int NODE_COUNT = dfs_pkg::NODE_COUNT_DEF
) (
  input  logic [NODE_COUNT*NODE_COUNT-1:0]     adj_i,
  input  logic [NODE_COUNT-1:0]                visited_i,
  input  logic [dfs_pkg::NODE_W-1:0]           cur_i,
  input  logic [$clog2(NODE_COUNT+1)-1:0]      nxt_i,
  input  logic [$clog2(NODE_COUNT+1)-1:0]      depth_i,
  output dfs_pkg::step_t                       step_o
);
  import dfs_pkg::*;

  localparam int ADJ_W  = NODE_COUNT * NODE_COUNT;
  localparam int ADJ_IW = $clog2(ADJ_W);
  localparam int LVL_W  = $clog2(NODE_COUNT);
  localparam int NXT_W  = $clog2(NODE_COUNT + 1);

  logic             exhausted;
  logic [NXT_W-1:0] nxt_s;
  logic [ADJ_IW-1:0] bit_idx;
  logic             edge_bit;
  logic             seen_bit;

  // neighbor index past the last node ends this level
  assign exhausted = (nxt_i >= NXT_W'(NODE_COUNT));
  assign nxt_s     = exhausted ? '0 : nxt_i;

  // matrix bit for the edge cur -> nxt
  assign bit_idx  = ADJ_IW'(int'(cur_i) * NODE_COUNT + int'(nxt_s));
  assign edge_bit = adj_i[bit_idx];
  assign seen_bit = visited_i[nxt_s[LVL_W-1:0]];

  assign step_o.exhausted = exhausted;
  assign step_o.take      = !exhausted && edge_bit && !seen_bit &&
                            (depth_i < NXT_W'(NODE_COUNT));

endmodule

### rtl/dfs_path_stack.sv
`timescale 1ns / 1ps

module dfs_path_stack #(
  parameter int NODE_COUNT = dfs_pkg::NODE_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              push_i,
  input  logic [$clog2(NODE_COUNT)-1:0]     wr_lvl_i,
  input  logic [dfs_pkg::NODE_W-1:0]        wr_node_i,
  input  logic [$clog2(NODE_COUNT+1)-1:0]   wr_next_i,
  input  logic [$clog2(NODE_COUNT)-1:0]     rd_lvl_i,
  output logic [dfs_pkg::NODE_W-1:0]        rd_node_o,
  output logic [$clog2(NODE_COUNT+1)-1:0]   rd_next_o
);
  import dfs_pkg::*;

  localparam int NXT_W = $clog2(NODE_COUNT + 1);

  logic [NODE_W-1:0] node_q [NODE_COUNT];
  logic [NXT_W-1:0]  next_q [NODE_COUNT];

  // saved parent levels, written on descend
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      node_q[wr_lvl_i] <= wr_node_i;
      next_q[wr_lvl_i] <= wr_next_i;
    end
  end

  // parent level restored on backtrack
  assign rd_node_o = node_q[rd_lvl_i];
  assign rd_next_o = next_q[rd_lvl_i];

endmodule

### rtl/dfs_visit_order.sv
`timescale 1ns / 1ps
// depth first walk: one start node in, one beat per visited node out; one matrix
// bit or one backtrack is tested per cycle while the output is not stalled.
// the first beat is valid the cycle after the test that finds the second
// node; a lone start node shows once its level is exhausted.
// asynchronous active-low reset: idle, empty output, trigger 3, matrix clear.
module dfs_visit_order #(
  parameter int NODE_COUNT = dfs_pkg::NODE_COUNT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // start node channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [dfs_pkg::NODE_W-1:0]         start_node_i,
  // visit channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [dfs_pkg::NODE_W-1:0]         visited_node_o,
  output logic                               is_trigger_o,
  output logic                               last_o,
  // register writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_index_i,
  input  logic [NODE_COUNT*NODE_COUNT-1:0]   cfg_data_i
);
  import dfs_pkg::*;

  `include "dfs_visit_order_macros.svh"

  localparam int ADJ_W = NODE_COUNT * NODE_COUNT;
  localparam int LVL_W = $clog2(NODE_COUNT);
  localparam int NXT_W = $clog2(NODE_COUNT + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [ADJ_W-1:0]      adj_q;
  logic [NODE_W-1:0]     trig_q;
  logic [NODE_COUNT-1:0] visited_q, visited_d;
  logic [NXT_W-1:0]      depth_q, depth_d;
  logic [NODE_W-1:0]     cur_q, cur_d;
  logic [NXT_W-1:0]      nxt_q, nxt_d;
  logic [NODE_W-1:0]     pend_q, pend_d;
  logic                  out_valid_q, out_valid_d;
  logic [NODE_W-1:0]     out_node_q, out_node_d;
  logic                  out_trig_q, out_trig_d;
  logic                  out_last_q, out_last_d;

  logic                  out_free;
  logic                  start_ok;
  logic                  push;
  logic [LVL_W-1:0]      wr_lvl;
  logic [LVL_W-1:0]      rd_lvl;
  logic [NODE_W-1:0]     rd_node;
  logic [NXT_W-1:0]      rd_next;
  step_t                 step;

  // neighbor test on the top of the path
  dfs_step_unit #(
    .NODE_COUNT (NODE_COUNT)
  ) u_step (
    .adj_i     (adj_q),
    .visited_i (visited_q),
    .cur_i     (cur_q),
    .nxt_i     (nxt_q),
    .depth_i   (depth_q),
    .step_o    (step)
  );

  // saved parent levels
  assign wr_lvl = LVL_W'(depth_q - NXT_W'(1));
  assign rd_lvl = LVL_W'(depth_q - NXT_W'(2));

  dfs_path_stack #(
    .NODE_COUNT (NODE_COUNT)
  ) u_stack (
    .clk_i     (clk_i),
    .push_i    (push),
    .wr_lvl_i  (wr_lvl),
    .wr_node_i (cur_q),
    .wr_next_i (nxt_q + NXT_W'(1)),
    .rd_lvl_i  (rd_lvl),
    .rd_node_o (rd_node),
    .rd_next_o (rd_next)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign start_ok = ({1'b0, start_node_i} < (NODE_W + 1)'(NODE_COUNT));

  // walk sequencer; the newest visit is held back until its last flag is known
  always_comb begin
    state_d     = state_q;
    visited_d   = visited_q;
    depth_d     = depth_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_node_d  = out_node_q;
    out_trig_d  = out_trig_q;
    out_last_d  = out_last_q;
    push        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && start_ok) begin
          for (int i = 0; i < NODE_COUNT; i++) begin
            visited_d[i] = ({1'b0, start_node_i} == (NODE_W + 1)'(i));
          end
          depth_d = NXT_W'(1);
          cur_d   = start_node_i;
          nxt_d   = '0;
          pend_d  = start_node_i;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (out_free) begin
          if (step.exhausted) begin
            if (depth_q == NXT_W'(1)) begin
              depth_d = '0;
              state_d = ST_FLUSH;
            end else begin
              depth_d = depth_q - NXT_W'(1);
              cur_d   = rd_node;
              nxt_d   = rd_next;
            end
          end else if (step.take) begin
            out_valid_d = 1'b1;
            out_node_d  = pend_q;
            out_trig_d  = (pend_q == trig_q);
            out_last_d  = 1'b0;
            pend_d      = NODE_W'(nxt_q);
            push        = 1'b1;
            visited_d[nxt_q[LVL_W-1:0]] = 1'b1;
            cur_d       = NODE_W'(nxt_q);
            nxt_d       = '0;
            depth_d     = depth_q + NXT_W'(1);
          end else begin
            nxt_d = nxt_q + NXT_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_node_d  = pend_q;
          out_trig_d  = (pend_q == trig_q);
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      visited_q   <= '0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      visited_q   <= visited_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
    end
  end

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q  <= '0;
      trig_q <= TRIG_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ADJ:  adj_q  <= cfg_data_i;
        CFG_TRIG: trig_q <= cfg_data_i[NODE_W-1:0];
        default:  adj_q  <= adj_q;
      endcase
    end
  end

  // walk and output payload
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    nxt_q      <= nxt_d;
    pend_q     <= pend_d;
    out_node_q <= out_node_d;
    out_trig_q <= out_trig_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign visited_node_o = out_node_q;
  assign is_trigger_o   = out_trig_q;
  assign last_o         = out_last_q;

  // checks
  `DFS_ASSERT(a_walk_depth, (state_q == ST_WALK) |-> (depth_q != '0))
  `DFS_ASSERT(a_walk_marks, (state_q == ST_WALK) |-> (visited_q != '0))
  `DFS_ASSERT(a_start_walk, (in_valid_i && !in_stall_o && start_ok) |=> (state_q == ST_WALK))
  `DFS_ASSERT(a_flush_last, (state_q == ST_FLUSH && out_free) |=> (state_q == ST_IDLE && out_valid_q && out_last_q))
  `DFS_ASSERT_ALWAYS(a_reset_idle, (!rst_ni) |=> (state_q == ST_IDLE && !out_valid_q))

endmodule
